@@ design/nstr_pkg.sv @@
// shared types and codes of the nested section trace recorder
package nstr_pkg;

   localparam int TS_W       = 48;
   localparam int NAME_W     = 16;
   localparam int COLOR_W    = 32;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 48;

   localparam logic [CMD_W-1:0] CMD_OPEN    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLOSE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MARKER  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_COLLECT = 2'd3;

   localparam logic [STATUS_W-1:0] ST_RECORD    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_TAG  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AGE_ENABLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_AGE    = 2'd2;

   localparam logic [COLOR_W-1:0] COLOR_RESET = 32'hFFFF_FFFF;

   typedef logic [TS_W-1:0]    ts_type;
   typedef logic [NAME_W-1:0]  name_type;
   typedef logic [COLOR_W-1:0] color_type;

   typedef struct packed {
      ts_type    start_ts;
      ts_type    end_ts;
      name_type  name;
      color_type color;
   } rec_type;

endpackage

@@ design/nstr_ring.sv @@
// history ring storage: one write port, one registered read port
module nstr_ring #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  nstr_pkg::rec_type wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output nstr_pkg::rec_type rd_data
);
   import nstr_pkg::*;

   rec_type mem_ff [DEPTH];
   rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/nstr_stack.sv @@
// section stack storage: label and start arrays, registered read of one entry
module nstr_stack #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic               clock,
   input  logic               label_we,
   input  logic               start_we,
   input  logic [AW-1:0]      wr_addr,
   input  nstr_pkg::name_type wr_label,
   input  nstr_pkg::ts_type   wr_start,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output nstr_pkg::name_type rd_label,
   output nstr_pkg::ts_type   rd_start
);
   import nstr_pkg::*;

   name_type label_mem_ff [DEPTH];
   ts_type   start_mem_ff [DEPTH];
   name_type rd_label_ff;
   ts_type   rd_start_ff;

   always_ff @(posedge clock) begin
      if (label_we) begin
         label_mem_ff[wr_addr] <= wr_label;
      end
      if (start_we) begin
         start_mem_ff[wr_addr] <= wr_start;
      end
      if (rd_en) begin
         rd_label_ff <= label_mem_ff[rd_addr];
         rd_start_ff <= start_mem_ff[rd_addr];
      end
   end

   assign rd_label = rd_label_ff;
   assign rd_start = rd_start_ff;

endmodule

@@ design/nstr_age_unit.sv @@
// age check: wrapping 48-bit subtract and compare against the limit
module nstr_age_unit (
   input  nstr_pkg::ts_type now_ts,
   input  nstr_pkg::ts_type start_ts,
   input  nstr_pkg::ts_type max_age,
   output logic             too_old
);
   import nstr_pkg::*;

   ts_type age;

   // age wraps modulo 2^48
   assign age     = now_ts - start_ts;
   assign too_old = age > max_age;

endmodule

@@ design/nested_section_trace_recorder_unit.sv @@
// top level of the nested section trace recorder: sequencer, registers and outputs
//
//   channel | direction | ports                         | moves
//   req     | in        | req_valid / req_stall          | one command word
//   rsp     | out       | rsp_valid / rsp_stall          | one record or status word
//   csr     | in        | csr_write / csr_index          | one register write
//
// open, close and marker: the word is accepted, then the stack and ring are updated together.
// collect walks the history newest first, an address and a compare step per record,
// set by the single registered read port of the ring and the one shared age comparator.
// a result waits in the output register while the next word can be accepted;
// a stalled output holds the walk until its register frees up.
// reset is synchronous and empties the ring and stack at once, no clearing pass.
module nested_section_trace_recorder_unit #(
   parameter int HISTORY_DEPTH = 64,
   parameter int STACK_DEPTH   = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [nstr_pkg::CMD_W-1:0]         req_command,
   input  nstr_pkg::ts_type                   req_now_cycles,
   input  nstr_pkg::name_type                 req_name_id,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [nstr_pkg::STATUS_W-1:0]      rsp_status,
   output nstr_pkg::ts_type                   rsp_start_cycles,
   output nstr_pkg::ts_type                   rsp_end_cycles,
   output nstr_pkg::name_type                 rsp_record_name,
   output nstr_pkg::color_type                rsp_record_color,
   output logic                               rsp_last,
   input  logic                               csr_write,
   input  logic [nstr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [nstr_pkg::CSR_DATA_W-1:0]    csr_data
);
   import nstr_pkg::*;

   localparam int RW = $clog2(HISTORY_DEPTH);
   localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [4:0] {
      S_IDLE      = 5'b00001,
      S_EXEC      = 5'b00010,
      S_WALK_ADDR = 5'b00100,
      S_WALK_CMP  = 5'b01000,
      S_FINISH    = 5'b10000
   } state_type;

   function automatic logic [RW-1:0] ring_inc(input logic [RW-1:0] i);
      return (i == RW'(HISTORY_DEPTH - 1)) ? '0 : i + RW'(1);
   endfunction

   function automatic logic [RW-1:0] ring_dec(input logic [RW-1:0] i);
      return (i == '0) ? RW'(HISTORY_DEPTH - 1) : i - RW'(1);
   endfunction

   state_type            state_ff, state_in;
   logic [CMD_W-1:0]     cmd_ff;
   ts_type               now_ff;
   name_type             name_ff;
   logic [CW-1:0]        stk_count_ff, stk_count_in;
   logic [RW-1:0]        wr_idx_ff, wr_idx_in;
   logic [RW-1:0]        oldest_ff, oldest_in;
   logic [RW-1:0]        walk_idx_ff, walk_idx_in;
   logic                 pend_valid_ff, pend_valid_in;
   rec_type              pend_ff, pend_in;
   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   rec_type              rsp_rec_ff;
   logic                 rsp_last_ff;
   color_type            color_ff;
   logic                 age_en_ff;
   ts_type               max_age_ff;

   logic                 req_accept;
   logic                 out_free;
   logic                 out_load;
   logic [STATUS_W-1:0]  out_status;
   rec_type              out_rec;
   logic                 out_last;

   logic                 ring_we;
   rec_type              ring_wdata;
   logic                 ring_re;
   logic [RW-1:0]        ring_raddr;
   rec_type              ring_rdata;

   logic                 stk_label_we;
   logic                 stk_start_we;
   logic [SW-1:0]        stk_waddr;
   ts_type               stk_wstart;
   logic                 stk_re;
   logic [CW-1:0]        cnt_m1;
   logic [CW-1:0]        cnt_m2;
   name_type             stk_rd_label;
   ts_type               stk_rd_start;
   logic                 stk_full;
   logic                 stk_empty;
   logic                 too_old;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign cnt_m1    = stk_count_ff - CW'(1);
   assign cnt_m2    = stk_count_ff - CW'(2);
   assign stk_full  = (stk_count_ff == CW'(STACK_DEPTH));
   assign stk_empty = (stk_count_ff == '0);
   assign stk_re    = (state_ff == S_IDLE);

   nstr_ring #(
      .DEPTH (HISTORY_DEPTH),
      .AW    (RW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (wr_idx_ff),
      .wr_data (ring_wdata),
      .rd_en   (ring_re),
      .rd_addr (ring_raddr),
      .rd_data (ring_rdata)
   );

   nstr_stack #(
      .DEPTH (STACK_DEPTH),
      .AW    (SW)
   ) u_stack (
      .clock    (clock),
      .label_we (stk_label_we),
      .start_we (stk_start_we),
      .wr_addr  (stk_waddr),
      .wr_label (name_ff),
      .wr_start (stk_wstart),
      .rd_en    (stk_re),
      .rd_addr  (cnt_m1[SW-1:0]),
      .rd_label (stk_rd_label),
      .rd_start (stk_rd_start)
   );

   nstr_age_unit u_age (
      .now_ts   (now_ff),
      .start_ts (ring_rdata.start_ts),
      .max_age  (max_age_ff),
      .too_old  (too_old)
   );

   always_comb begin
      state_in      = state_ff;
      stk_count_in  = stk_count_ff;
      wr_idx_in     = wr_idx_ff;
      oldest_in     = oldest_ff;
      walk_idx_in   = walk_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_load      = 1'b0;
      out_status    = ST_RECORD;
      out_rec       = '0;
      out_last      = 1'b0;
      ring_we       = 1'b0;
      ring_wdata    = '{start_ts: stk_rd_start, end_ts: now_ff, name: stk_rd_label,
                        color: color_ff};
      ring_re       = 1'b0;
      ring_raddr    = ring_dec(walk_idx_ff);
      stk_label_we  = 1'b0;
      stk_start_we  = 1'b0;
      stk_waddr     = stk_count_ff[SW-1:0];
      stk_wstart    = now_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (cmd_ff)
               CMD_OPEN: begin
                  if (stk_full) begin
                     if (out_free) begin
                        out_load   = 1'b1;
                        out_status = ST_OVERFLOW;
                        out_last   = 1'b1;
                        state_in   = S_IDLE;
                     end
                  end else begin
                     // split record for the enclosing section
                     ring_we      = !stk_empty;
                     stk_label_we = 1'b1;
                     stk_start_we = 1'b1;
                     stk_count_in = stk_count_ff + CW'(1);
                     state_in     = S_IDLE;
                  end
               end
               CMD_CLOSE: begin
                  if (stk_empty) begin
                     if (out_free) begin
                        out_load   = 1'b1;
                        out_status = ST_UNDERFLOW;
                        out_last   = 1'b1;
                        state_in   = S_IDLE;
                     end
                  end else begin
                     ring_we      = 1'b1;
                     stk_count_in = cnt_m1;
                     // enclosing section restarts now
                     stk_start_we = (stk_count_ff > CW'(1));
                     stk_waddr    = cnt_m2[SW-1:0];
                     state_in     = S_IDLE;
                  end
               end
               CMD_MARKER: begin
                  ring_we    = 1'b1;
                  ring_wdata = '{start_ts: now_ff, end_ts: now_ff, name: name_ff,
                                 color: color_ff};
                  state_in   = S_IDLE;
               end
               CMD_COLLECT: begin
                  if (!stk_empty) begin
                     pend_valid_in = 1'b1;
                     pend_in       = '{start_ts: stk_rd_start, end_ts: now_ff,
                                       name: stk_rd_label, color: color_ff};
                  end
                  walk_idx_in = wr_idx_ff;
                  state_in    = S_WALK_ADDR;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_WALK_ADDR: begin
            if (walk_idx_ff == oldest_ff) begin
               state_in = S_FINISH;
            end else begin
               ring_re     = 1'b1;
               walk_idx_in = ring_dec(walk_idx_ff);
               state_in    = S_WALK_CMP;
            end
         end
         S_WALK_CMP: begin
            if (age_en_ff && too_old) begin
               state_in = S_FINISH;
            end else if (!pend_valid_ff) begin
               pend_valid_in = 1'b1;
               pend_in       = ring_rdata;
               state_in      = S_WALK_ADDR;
            end else if (out_free) begin
               // older record found, so the held one is not the final word
               out_load = 1'b1;
               out_rec  = pend_ff;
               pend_in  = ring_rdata;
               state_in = S_WALK_ADDR;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               out_load      = 1'b1;
               out_last      = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
               if (pend_valid_ff) begin
                  out_rec = pend_ff;
               end else begin
                  out_status = ST_EMPTY;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (ring_we) begin
         wr_idx_in = ring_inc(wr_idx_ff);
         // one slot stays empty: drop the oldest when the writer catches up
         if (ring_inc(wr_idx_ff) == oldest_ff) begin
            oldest_in = ring_inc(oldest_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         stk_count_ff  <= '0;
         wr_idx_ff     <= '0;
         oldest_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         stk_count_ff  <= stk_count_in;
         wr_idx_ff     <= wr_idx_in;
         oldest_ff     <= oldest_in;
         pend_valid_ff <= pend_valid_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      walk_idx_ff <= walk_idx_in;
      pend_ff     <= pend_in;
      if (req_accept) begin
         cmd_ff  <= req_command;
         now_ff  <= req_now_cycles;
         name_ff <= req_name_id;
      end
      if (out_load) begin
         rsp_status_ff <= out_status;
         rsp_rec_ff    <= out_rec;
         rsp_last_ff   <= out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff   <= COLOR_RESET;
         age_en_ff  <= 1'b0;
         max_age_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_COLOR_TAG:  color_ff   <= csr_data[COLOR_W-1:0];
            CSR_AGE_ENABLE: age_en_ff  <= csr_data[0];
            CSR_MAX_AGE:    max_age_ff <= csr_data[TS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_start_cycles = rsp_rec_ff.start_ts;
   assign rsp_end_cycles   = rsp_rec_ff.end_ts;
   assign rsp_record_name  = rsp_rec_ff.name;
   assign rsp_record_color = rsp_rec_ff.color;
   assign rsp_last         = rsp_last_ff;

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      stk_count_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_ring_not_empty: assert property (@(posedge clock) disable iff (reset)
      ring_we |=> (wr_idx_ff != oldest_ff))
      else $error("ring reads empty after a write");

   a_pend_in_walk: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == S_WALK_ADDR || state_ff == S_WALK_CMP ||
                         state_ff == S_FINISH))
      else $error("held record outside a collect walk");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_EXEC))
      else $error("accepted word not executed");

endmodule
